// ===== sv/sbp_pkg.sv =====
`default_nettype none

package sbp_pkg;

   // Operation codes on the request channel
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_MOVE = 2'd1;
   localparam logic [1:0] OP_HOME = 2'd2;
   localparam logic [1:0] OP_NOP  = 2'd3;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_SLOW_DELAY = 2'd0;
   localparam logic [1:0] REG_FAST_DELAY = 2'd1;
   localparam logic [1:0] REG_QUARTER    = 2'd2;
   localparam logic [1:0] REG_MARGIN     = 2'd3;

   // Register reset values
   localparam logic [7:0] SLOW_DELAY_RST = 8'd20;
   localparam logic [7:0] FAST_DELAY_RST = 8'd12;
   localparam logic [8:0] QUARTER_RST    = 9'd50;
   localparam logic [8:0] MARGIN_RST     = 9'd15;

   // Coil drive patterns for phases one to four
   localparam logic [7:0] COIL_PH1 = 8'b0011_0000;
   localparam logic [7:0] COIL_PH2 = 8'b0000_0110;
   localparam logic [7:0] COIL_PH3 = 8'b0010_1000;
   localparam logic [7:0] COIL_PH4 = 8'b0000_0101;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_MOVE,
      KIND_HOME,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] target_bin;
      logic       home_sensor;
   } cmd_type;

   typedef struct packed {
      logic [7:0] slow_step_delay;
      logic [7:0] fast_step_delay;
      logic [8:0] quarter_turn_steps;
      logic [8:0] accel_margin;
   } cfg_type;

   // Next phase going clockwise; phase zero (no phase yet) goes to one
   function automatic logic [2:0] phase_cw(input logic [2:0] phase);
      phase_cw = {1'b0, phase[1:0]} + 3'd1;
   endfunction

   function automatic logic [2:0] phase_ccw(input logic [2:0] phase);
      if (phase <= 3'd1 || phase > 3'd4) begin
         phase_ccw = 3'd4;
      end else begin
         phase_ccw = phase - 3'd1;
      end
   endfunction

   function automatic logic [7:0] coil_pattern(input logic [2:0] phase);
      logic [1:0] sel;
      sel = phase[1:0] - 2'd1;
      case (sel)
         2'd0:    coil_pattern = COIL_PH1;
         2'd1:    coil_pattern = COIL_PH2;
         2'd2:    coil_pattern = COIL_PH3;
         default: coil_pattern = COIL_PH4;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== sv/sbp_front.sv =====
`default_nettype none

module sbp_front
   import sbp_pkg::*;
(
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,
   input  wire logic                  queue_full,
   output logic                       push,
   output cmd_type                    push_cmd
);

   kind_type kind;

   always_comb begin
      unique case (req_tuser)
         OP_TICK: kind = KIND_TICK;
         OP_MOVE: kind = KIND_MOVE;
         OP_HOME: kind = KIND_HOME;
         default: kind = KIND_NOP;
      endcase
   end

   assign req_tready           = !queue_full;
   assign push                 = req_tvalid && !queue_full;
   assign push_cmd.kind        = kind;
   assign push_cmd.target_bin  = req_tdata[1:0];
   assign push_cmd.home_sensor = req_tdata[2];

endmodule

`default_nettype wire

// ===== sv/sbp_queue.sv =====
`default_nettype none

module sbp_queue
   import sbp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output logic         empty,
   output logic         full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FULL_CNT);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sbp_back.sv =====
`default_nettype none

module sbp_back
   import sbp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire cmd_type               head_cmd,
   input  wire logic                  queue_empty,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_MOVE,
      MODE_HOME
   } mode_type;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  tray_ff, tray_in;
   logic [9:0]  left_ff, left_in;
   logic [9:0]  num_ff, num_in;
   logic [9:0]  total_ff, total_in;
   logic [7:0]  tick_ff, tick_in;
   logic [7:0]  delay_ff, delay_in;
   logic        dir_ff, dir_in;
   mode_type    mode_ff, mode_in;
   logic [7:0]  drive_ff, drive_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic        stepped;
   logic        ignored;
   logic        move_step;
   logic [1:0]  diff;
   logic [9:0]  margin;

   // Advance when the output register is free or being drained
   assign pop        = !queue_empty && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign diff       = head_cmd.target_bin - tray_ff;
   assign margin     = {1'b0, cfg.accel_margin};

   always_comb begin
      phase_in  = phase_ff;
      tray_in   = tray_ff;
      left_in   = left_ff;
      num_in    = num_ff;
      total_in  = total_ff;
      tick_in   = tick_ff;
      delay_in  = delay_ff;
      dir_in    = dir_ff;
      mode_in   = mode_ff;
      drive_in  = drive_ff;
      stepped   = 1'b0;
      ignored   = 1'b0;
      move_step = 1'b0;

      case (head_cmd.kind) inside
         KIND_MOVE, KIND_HOME: begin
            if (mode_ff != MODE_IDLE) begin
               ignored = 1'b1;
            end else if (head_cmd.kind == KIND_MOVE) begin
               dir_in = 1'b0;
               case (diff)
                  2'd1:    total_in = {1'b0, cfg.quarter_turn_steps};
                  2'd3: begin
                     total_in = {1'b0, cfg.quarter_turn_steps};
                     dir_in   = 1'b1;
                  end
                  2'd2:    total_in = {cfg.quarter_turn_steps, 1'b0};
                  default: total_in = '0;
               endcase
               tray_in  = head_cmd.target_bin;
               left_in  = total_in;
               num_in   = '0;
               delay_in = cfg.slow_step_delay;
               if (total_in != '0) begin
                  mode_in   = MODE_MOVE;
                  move_step = 1'b1;
               end
            end else if (head_cmd.home_sensor) begin
               tray_in = 2'd1;
            end else begin
               mode_in  = MODE_HOME;
               phase_in = 3'd1;
               drive_in = coil_pattern(3'd1);
               tick_in  = cfg.slow_step_delay;
               stepped  = 1'b1;
            end
         end
         KIND_TICK: begin
            if (mode_ff != MODE_IDLE) begin
               if (tick_ff > 8'd1) begin
                  tick_in = tick_ff - 8'd1;
               end else begin
                  tick_in = '0;
                  if (mode_ff == MODE_MOVE) begin
                     if (left_ff != '0) begin
                        move_step = 1'b1;
                     end else begin
                        mode_in = MODE_IDLE;
                     end
                  end else if (head_cmd.home_sensor) begin
                     tray_in = 2'd1;
                     mode_in = MODE_IDLE;
                  end else begin
                     phase_in = phase_cw(phase_ff);
                     drive_in = coil_pattern(phase_in);
                     tick_in  = cfg.slow_step_delay;
                     stepped  = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (move_step) begin
         phase_in = dir_in ? phase_ccw(phase_in) : phase_cw(phase_in);
         drive_in = coil_pattern(phase_in);
         tick_in  = delay_in;
         // Switch to the fast delay once clear of both ends of the move
         if (num_in >= margin && total_in >= num_in && (total_in - num_in) >= margin) begin
            delay_in = cfg.fast_step_delay;
         end
         num_in  = num_in + 10'd1;
         left_in = left_in - 10'd1;
         stepped = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, ignored, tray_in, (mode_in != MODE_IDLE), stepped, drive_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         tray_ff      <= '0;
         left_ff      <= '0;
         num_ff       <= '0;
         total_ff     <= '0;
         tick_ff      <= '0;
         delay_ff     <= SLOW_DELAY_RST;
         dir_ff       <= 1'b0;
         mode_ff      <= MODE_IDLE;
         drive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            tray_ff  <= tray_in;
            left_ff  <= left_in;
            num_ff   <= num_in;
            total_ff <= total_in;
            tick_ff  <= tick_in;
            delay_ff <= delay_in;
            dir_ff   <= dir_in;
            mode_ff  <= mode_in;
            drive_ff <= drive_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== sv/stepper_bin_positioner.sv =====
// Stepper bin positioner: steps a four-phase motor that turns a four-bin tray.
// Request channel (req_): one item per tick or command. req_tuser carries the
// operation (tick, move, home, no-op); req_tdata carries target bin and home sensor.
// Response channel (rsp_): exactly one item per request, in order, giving the coil
// pattern, step flag, busy, current bin and command-ignored flag.
// Configuration (csr_): APB-style, four registers at byte offsets 0, 4, 8, 12
// (slow delay, fast delay, quarter-turn steps, acceleration margin); write only
// while no item is in flight.
// Throughput: one item per cycle while the response is not stalled. A request is
// written into the command queue when accepted; the execute stage then pops it,
// updates the motor state and loads the output register.
// The front decoder keeps accepting while the response is stalled until the
// QUEUE_DEPTH-entry command queue fills; then req_tready drops.
// Reset: synchronous; empties the queue and output register, clears motor state
// to idle at bin 0 with no coil phase, and loads the register reset values.
`default_nettype none

module stepper_bin_positioner
   import sbp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [1:0] target_bin, [2] home_sensor
   input  wire logic [1:0]            req_tuser,  // [1:0] operation
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] coil_pattern, [8] step_taken, [9] busy_res, [11:10] current_bin,
   // [12] command_ignored
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [3:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   cfg_type     cfg_ff;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic        push, pop, queue_full, queue_empty;
   cmd_type     push_cmd, head_cmd;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_step_delay    <= SLOW_DELAY_RST;
         cfg_ff.fast_step_delay    <= FAST_DELAY_RST;
         cfg_ff.quarter_turn_steps <= QUARTER_RST;
         cfg_ff.accel_margin       <= MARGIN_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SLOW_DELAY: cfg_ff.slow_step_delay    <= csr_pwdata[7:0];
            REG_FAST_DELAY: cfg_ff.fast_step_delay    <= csr_pwdata[7:0];
            REG_QUARTER:    cfg_ff.quarter_turn_steps <= csr_pwdata[8:0];
            default:        cfg_ff.accel_margin       <= csr_pwdata[8:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SLOW_DELAY: csr_prdata = {24'd0, cfg_ff.slow_step_delay};
         REG_FAST_DELAY: csr_prdata = {24'd0, cfg_ff.fast_step_delay};
         REG_QUARTER:    csr_prdata = {23'd0, cfg_ff.quarter_turn_steps};
         default:        csr_prdata = {23'd0, cfg_ff.accel_margin};
      endcase
   end

   sbp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   sbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   sbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_cmd    (head_cmd),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== sv/sbp_checker.sv =====
`default_nettype none

module sbp_checker
   import sbp_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Nothing leaves the block in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A step is only written while moving or homing
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[9])
      else $error("step taken while idle");

   // A dropped command leaves the motor busy and untouched
   a_ignore_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |-> rsp_tdata[9] && !rsp_tdata[8])
      else $error("ignored command with step or while idle");

endmodule

bind stepper_bin_positioner sbp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import sbp_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_ITEMS = 200;

   typedef enum logic [1:0] {
      DRIVE_IDLE,
      DRIVE_MOVE,
      DRIVE_HOME
   } drive_mode_type;

   // Fields of one response item, lowest bits last
   typedef struct packed {
      logic       ignored;
      logic [1:0] bin;
      logic       busy;
      logic       stepped;
      logic [7:0] coil;
   } tray_status_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;  // [1:0] target_bin, [2] home_sensor
   logic [1:0]            req_tuser   = OP_NOP;  // [1:0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // [7:0] coil_pattern, [8] step_taken, [9] busy_res, [11:10] current_bin,
   // [12] command_ignored
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [3:0]            csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Register copies
   logic [7:0]  slow_m;
   logic [7:0]  fast_m;
   logic [8:0]  quarter_m;
   logic [8:0]  margin_m;

   // Motor state
   logic [2:0]  phase_m;
   logic [1:0]  bin_m;
   logic [9:0]  left_m;
   logic [9:0]  index_m;
   logic [9:0]  total_m;
   logic [7:0]  wait_m;
   logic [7:0]  delay_m;
   logic        ccw_m;
   drive_mode_type mode_m;
   logic [7:0]  coil_m;

   tray_status_type pending_status_q[$];
   tray_status_type oldest_status;

   int items_sent    = 0;
   int results_seen  = 0;
   int mismatches    = 0;
   int config_writes = 0;
   int burst_left    = 0;
   bit gaps_on       = 1'b1;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   stepper_bin_positioner DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void note_mismatch(input string what, input int unsigned want,
                                         input int unsigned got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
      end
   endfunction

   function automatic void set_phase(input logic [2:0] ph);
      phase_m = ph;
      case (ph[1:0])
         2'd1:    coil_m = COIL_PH1;
         2'd2:    coil_m = COIL_PH2;
         2'd3:    coil_m = COIL_PH3;
         default: coil_m = COIL_PH4;
      endcase
   endfunction

   function automatic void take_step();
      logic [2:0] nxt;
      if (!ccw_m) begin
         nxt = {1'b0, phase_m[1:0]} + 3'd1;
      end else if (phase_m <= 3'd1 || phase_m > 3'd4) begin
         nxt = 3'd4;
      end else begin
         nxt = phase_m - 3'd1;
      end
      set_phase(nxt);
      wait_m = delay_m;
      // switch to the fast delay once clear of both ends; never switch back
      if (index_m >= {1'b0, margin_m} && total_m >= index_m &&
          (total_m - index_m) >= {1'b0, margin_m}) begin
         delay_m = fast_m;
      end
      index_m = index_m + 10'd1;
      left_m  = left_m - 10'd1;
   endfunction

   function automatic tray_status_type advance_motor(input logic [1:0] op,
                                                     input logic [1:0] target,
                                                     input logic sensor);
      tray_status_type st;
      logic [1:0]      diff;
      st = '0;
      if (op == OP_MOVE || op == OP_HOME) begin
         if (mode_m != DRIVE_IDLE) begin
            st.ignored = 1'b1;
         end else if (op == OP_MOVE) begin
            diff  = target - bin_m;
            ccw_m = 1'b0;
            case (diff)
               2'd1:    total_m = {1'b0, quarter_m};
               2'd2:    total_m = {quarter_m, 1'b0};
               2'd3: begin
                  total_m = {1'b0, quarter_m};
                  ccw_m   = 1'b1;
               end
               default: total_m = '0;
            endcase
            bin_m   = target;
            left_m  = total_m;
            index_m = '0;
            delay_m = slow_m;
            if (left_m != '0) begin
               mode_m = DRIVE_MOVE;
               take_step();
               st.stepped = 1'b1;
            end
         end else if (sensor) begin
            bin_m = 2'd1;
         end else begin
            mode_m = DRIVE_HOME;
            set_phase(3'd1);
            wait_m = slow_m;
            st.stepped = 1'b1;
         end
      end else if (op == OP_TICK && mode_m != DRIVE_IDLE) begin
         if (wait_m > 8'd1) begin
            wait_m = wait_m - 8'd1;
         end else begin
            wait_m = '0;
            if (mode_m == DRIVE_MOVE) begin
               if (left_m != '0) begin
                  take_step();
                  st.stepped = 1'b1;
               end else begin
                  mode_m = DRIVE_IDLE;
               end
            end else if (sensor) begin
               bin_m  = 2'd1;
               mode_m = DRIVE_IDLE;
            end else begin
               set_phase({1'b0, phase_m[1:0]} + 3'd1);
               wait_m = slow_m;
               st.stepped = 1'b1;
            end
         end
      end
      st.coil = coil_m;
      st.busy = (mode_m != DRIVE_IDLE);
      st.bin  = bin_m;
      return st;
   endfunction

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status_q.size() == 0) begin
            note_mismatch("item with nothing expected", 0, rsp_tdata);
         end else begin
            oldest_status = pending_status_q.pop_front();
            results_seen++;
            if (rsp_tdata[7:0] != oldest_status.coil)
               note_mismatch("coil_pattern", oldest_status.coil, rsp_tdata[7:0]);
            if (rsp_tdata[8] != oldest_status.stepped)
               note_mismatch("step_taken", oldest_status.stepped, rsp_tdata[8]);
            if (rsp_tdata[9] != oldest_status.busy)
               note_mismatch("busy_res", oldest_status.busy, rsp_tdata[9]);
            if (rsp_tdata[11:10] != oldest_status.bin)
               note_mismatch("current_bin", oldest_status.bin, rsp_tdata[11:10]);
            if (rsp_tdata[12] != oldest_status.ignored)
               note_mismatch("command_ignored", oldest_status.ignored, rsp_tdata[12]);
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD;
         rsp_tready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_pct == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("stalled for %0d cycles with %0d results outstanding",
                  quiet_cycles, pending_status_q.size());
         $display("stepper_bin_positioner regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [1:0] target,
                            input logic sensor);
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on && $urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'd0, sensor, target};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_status_q.push_back(advance_motor(op, target, sensor));
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_status_q.size() != 0) @(posedge clock);
   endtask

   // Tick until the motor settles; mix in commands that land while busy
   task automatic run_to_idle(input int sensor_pct, input int cmd_pct);
      logic sensor;
      while (mode_m != DRIVE_IDLE) begin
         sensor = ($urandom_range(0, 99) < sensor_pct);
         if ($urandom_range(0, 99) < cmd_pct) begin
            send_item(2'($urandom_range(OP_MOVE, OP_NOP)), 2'($urandom_range(0, 3)), sensor);
         end else begin
            send_item(OP_TICK, 2'($urandom_range(0, 3)), sensor);
         end
      end
   endtask

   task automatic check_register(input logic [1:0] idx);
      logic [31:0] want;
      case (idx)
         REG_SLOW_DELAY: want = {24'd0, slow_m};
         REG_FAST_DELAY: want = {24'd0, fast_m};
         REG_QUARTER:    want = {23'd0, quarter_m};
         default:        want = {23'd0, margin_m};
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata != want) note_mismatch("register readback", want, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [8:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {23'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_SLOW_DELAY: slow_m    = value[7:0];
         REG_FAST_DELAY: fast_m    = value[7:0];
         REG_QUARTER:    quarter_m = value;
         default:        margin_m  = value;
      endcase
      config_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      check_register(idx);
   endtask

   task automatic set_config(input logic [7:0] slow, input logic [7:0] fast,
                             input logic [8:0] quarter, input logic [8:0] margin);
      run_to_idle(50, 0);
      drain();
      csr_write(REG_SLOW_DELAY, {1'b0, slow});
      csr_write(REG_FAST_DELAY, {1'b0, fast});
      csr_write(REG_QUARTER, quarter);
      csr_write(REG_MARGIN, margin);
   endtask

   task automatic test_reset_defaults();
      check_register(REG_SLOW_DELAY);
      check_register(REG_FAST_DELAY);
      check_register(REG_QUARTER);
      check_register(REG_MARGIN);
      // idle tick, no-op and a move to the current bin leave the tray alone
      send_item(OP_TICK, 2'd2, 1'b1);
      send_item(OP_NOP, 2'd1, 1'b0);
      send_item(OP_MOVE, bin_m, 1'b0);
      drain();
   endtask

   task automatic test_directed();
      set_config(8'd2, 8'd1, 9'd3, 9'd1);
      // bin 0 to bin 3 turns counter-clockwise from no phase
      send_item(OP_MOVE, 2'd3, 1'b0);
      run_to_idle(0, 0);
      send_item(OP_NOP, 2'd3, 1'b1);
      send_item(OP_TICK, 2'd0, 1'b1);
      send_item(OP_MOVE, bin_m, 1'b0);
      send_item(OP_MOVE, 2'd0, 1'b1);
      send_item(OP_MOVE, 2'd3, 1'b0);
      send_item(OP_HOME, 2'd1, 1'b1);
      send_item(OP_NOP, 2'd2, 1'b0);
      run_to_idle(0, 0);
      send_item(OP_MOVE, bin_m + 2'd2, 1'b0);
      run_to_idle(0, 0);
      send_item(OP_MOVE, bin_m - 2'd1, 1'b1);
      run_to_idle(0, 0);
      send_item(OP_HOME, 2'd0, 1'b1);
      send_item(OP_HOME, 2'd3, 1'b0);
      // sensor seen mid-wait is ignored; only the tick that ends a wait samples it
      send_item(OP_TICK, 2'd0, 1'b1);
      send_item(OP_TICK, 2'd0, 1'b0);
      send_item(OP_TICK, 2'd0, 1'b0);
      send_item(OP_TICK, 2'd0, 1'b1);
      run_to_idle(100, 0);
   endtask

   task automatic test_zero_registers();
      set_config(8'd0, 8'd0, 9'd0, 9'd0);
      send_item(OP_MOVE, bin_m + 2'd1, 1'b0);
      send_item(OP_MOVE, bin_m + 2'd2, 1'b0);
      send_item(OP_TICK, 2'd0, 1'b0);
      set_config(8'd0, 8'd0, 9'd2, 9'd0);
      send_item(OP_MOVE, bin_m + 2'd1, 1'b0);
      run_to_idle(0, 0);
      send_item(OP_HOME, 2'd0, 1'b0);
      run_to_idle(30, 0);
   endtask

   task automatic test_register_extremes();
      // longest wait after a single step; commands in the wait are dropped
      set_config(8'd255, 8'd1, 9'd1, 9'd0);
      send_item(OP_MOVE, bin_m + 2'd1, 1'b0);
      run_to_idle(0, 5);
      set_config(8'd1, 8'd255, 9'd511, 9'd511);
      send_item(OP_MOVE, bin_m, 1'b0);
      send_item(OP_HOME, 2'd2, 1'b1);
      send_item(OP_TICK, 2'd0, 1'b0);
   endtask

   task automatic test_random_traffic();
      int first_item;
      int phase_end;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         gaps_on = $urandom_range(0, 1);
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            default: stall_pct = 60;
         endcase
         set_config(8'($urandom_range(0, 5)), 8'($urandom_range(1, 5)),
                    9'($urandom_range(1, 8)), 9'($urandom_range(0, 4)));
         phase_end = items_sent + 100;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 9) < 7) begin
               if ($urandom_range(0, 2) != 0) begin
                  send_item(OP_MOVE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
               end else begin
                  send_item(OP_HOME, 2'($urandom_range(0, 3)), ($urandom_range(0, 4) == 0));
               end
               run_to_idle(20, 10);
            end else begin
               send_item(2'($urandom_range(OP_TICK, OP_NOP)), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   task automatic test_backpressure();
      set_config(8'd2, 8'd1, 9'd6, 9'd1);
      gaps_on   = 1'b0;
      stall_pct = 30;
      hold_requests++;
      repeat (60) begin
         if (mode_m == DRIVE_IDLE) begin
            send_item(OP_MOVE, 2'($urandom_range(0, 3)), 1'b0);
         end else begin
            send_item(OP_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         end
      end
      // hold the sender until every result is back
      drain();
      gaps_on = 1'b1;
      run_to_idle(50, 10);
   endtask

   initial begin
      slow_m    = SLOW_DELAY_RST;
      fast_m    = FAST_DELAY_RST;
      quarter_m = QUARTER_RST;
      margin_m  = MARGIN_RST;
      phase_m   = '0;
      bin_m     = '0;
      left_m    = '0;
      index_m   = '0;
      total_m   = '0;
      wait_m    = '0;
      delay_m   = SLOW_DELAY_RST;
      ccw_m     = 1'b0;
      mode_m    = DRIVE_IDLE;
      coil_m    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed();
      test_zero_registers();
      test_register_extremes();
      test_random_traffic();
      test_backpressure();

      drain();
      repeat (10) @(posedge clock);
      if (pending_status_q.size() != 0) begin
         note_mismatch("results never delivered", pending_status_q.size(), 0);
      end
      $display("sent %0d items, checked %0d results, %0d register writes", items_sent,
               results_seen, config_writes);
      $display("covered reset defaults, zero and extreme registers, homing, ignored %s",
               "commands, random stalls and a long output hold-off");
      if (mismatches == 0) begin
         $display("stepper_bin_positioner regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("stepper_bin_positioner regression: fail");
      end
      $finish;
   end

endmodule

// ===== stepper_bin_positioner.f =====
sv/sbp_pkg.sv
sv/sbp_front.sv
sv/sbp_queue.sv
sv/sbp_back.sv
sv/stepper_bin_positioner.sv
sv/sbp_checker.sv
bench/tb.sv
